FILE: src/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
// Used by the controller, the datapath and the top level.
package sha_pkg;

   typedef logic [31:0] word_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [3:0] OUT_WORDS = 4'd8;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PAD  = 6'b000010,
      ST_LEN  = 6'b000100,
      ST_COMP = 6'b001000,
      ST_ADD  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SRC_MSG,
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         put_byte;
      byte_src_type byte_src;
      logic         count_len;
      logic         load_vars;
      logic         round_en;
      logic [5:0]   round;
      logic         add_chain;
      logic         finish;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       out_empty;
   } status_type;

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: src/sha_req_if.sv
// Input channel of the SHA-256 hasher: one message byte word per handshake.
// Depends on nothing.
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

FILE: src/sha_rsp_if.sv
// Result channel of the SHA-256 hasher: one digest word per handshake.
// Depends on nothing.
interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   modport source (output valid, digest_word, word_number, last_word, input ready);
   modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

FILE: src/sha_ctrl.sv
// Sequencer of the SHA-256 hasher: byte intake, padding, 64 rounds, chain add, finish.
// Depends on sha_pkg; drives the datapath through cmd_type and reads status_type.
module sha_ctrl import sha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       byte_present,
   input  logic       end_of_message,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic [5:0] round_ff, round_in;
   logic       pad_first_ff, pad_first_in;
   logic       accept;
   logic       at_last;

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready;
   assign at_last  = (status.fill == LAST_POS);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      pad_first_in = pad_first_ff;
      cmd          = '0;
      cmd.byte_src = SRC_MSG;
      cmd.round    = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.put_byte  = byte_present;
               cmd.count_len = byte_present;
               if (end_of_message) begin
                  pad_first_in = 1'b1;
               end
               if (byte_present && at_last) begin
                  cmd.load_vars = 1'b1;
                  state_in      = ST_COMP;
                  ret_in        = end_of_message ? ST_PAD : ST_IDLE;
               end else if (end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.put_byte = 1'b1;
            cmd.byte_src = pad_first_ff ? SRC_PAD : SRC_ZERO;
            pad_first_in = 1'b0;
            if (at_last) begin
               cmd.load_vars = 1'b1;
               state_in      = ST_COMP;
               ret_in        = ST_PAD;
            end else if (status.fill == LEN_POS - 6'd1) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.put_byte = 1'b1;
            cmd.byte_src = SRC_LEN;
            if (at_last) begin
               cmd.load_vars = 1'b1;
               state_in      = ST_COMP;
               ret_in        = ST_DONE;
            end
         end
         ST_COMP: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == LAST_POS) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            state_in      = ret_ff;
         end
         ST_DONE: begin
            if (status.out_empty) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         round_ff     <= '0;
         pad_first_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         pad_first_ff <= pad_first_in;
      end
   end

   a_comp_block_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMP |-> status.fill == 6'd0)
      else $error("compression running on a partly filled block");

   a_len_in_tail: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LEN |-> status.fill[5:3] == 3'b111)
      else $error("length bytes outside the block tail");

   a_add_after_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |-> $past(state_ff) == ST_COMP && $past(round_ff) == LAST_POS)
      else $error("chain add without a full round sequence");

endmodule

FILE: src/sha_dp.sv
// Datapath of the SHA-256 hasher: byte packing, message schedule window, round
// logic, chaining state, bit count and the digest output buffer. Depends on sha_pkg.
module sha_dp import sha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [7:0] msg_byte,
   output logic       out_valid,
   input  logic       out_ready,
   output word_type   digest_word,
   output logic [2:0] word_number,
   output logic       last_word
);

   logic [5:0]  fill_ff;
   logic [23:0] acc_ff;
   word_type    win_ff   [16];
   word_type    vars_ff  [8];
   word_type    chain_ff [8];
   word_type    obuf_ff  [8];
   logic [63:0] len_ff;
   logic [3:0]  ocnt_ff;

   logic [7:0]  byte_val;
   word_type    packed_word;
   word_type    w_next;
   word_type    t1;
   word_type    t2;
   word_type    ch;
   word_type    mj;
   logic        word_done;
   logic        out_fire;

   always_comb begin
      case (cmd.byte_src)
         SRC_MSG:  byte_val = msg_byte;
         SRC_PAD:  byte_val = PAD_BYTE;
         SRC_ZERO: byte_val = 8'h00;
         SRC_LEN:  byte_val = len_ff[{~fill_ff[2:0], 3'b000} +: 8];
         default:  byte_val = 8'h00;
      endcase
   end

   assign packed_word = {acc_ff, byte_val};
   assign word_done   = cmd.put_byte && (fill_ff[1:0] == 2'b11);

   assign w_next = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
   assign ch     = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign mj     = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                   ^ (vars_ff[1] & vars_ff[2]);
   assign t1     = vars_ff[7] + big_sigma1(vars_ff[4]) + ch + ROUND_K[cmd.round] + win_ff[0];
   assign t2     = big_sigma0(vars_ff[0]) + mj;

   assign out_valid   = (ocnt_ff != 4'd0);
   assign out_fire    = out_valid && out_ready;
   assign digest_word = obuf_ff[0];
   assign word_number = 3'(OUT_WORDS - ocnt_ff);
   assign last_word   = (ocnt_ff == 4'd1);

   assign status.fill      = fill_ff;
   assign status.out_empty = (ocnt_ff == 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.put_byte) begin
         fill_ff <= fill_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put_byte && !word_done) begin
         acc_ff <= {acc_ff[15:0], byte_val};
      end
   end

   always_ff @(posedge clock) begin
      if (word_done || cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= word_done ? packed_word : w_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            vars_ff[i] <= '0;
         end
      end else if (cmd.load_vars) begin
         vars_ff <= chain_ff;
      end else if (cmd.round_en) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         chain_ff <= INIT_HASH;
      end else if (cmd.add_chain) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + vars_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         len_ff <= '0;
      end else if (cmd.count_len) begin
         len_ff <= len_ff + 64'd8;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         obuf_ff <= chain_ff;
      end else if (out_fire) begin
         for (int i = 0; i < 7; i++) begin
            obuf_ff[i] <= obuf_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= '0;
      end else if (cmd.finish) begin
         ocnt_ff <= OUT_WORDS;
      end else if (out_fire) begin
         ocnt_ff <= ocnt_ff - 4'd1;
      end
   end

   a_ocnt_range: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= OUT_WORDS)
      else $error("digest buffer count out of range");

   a_finish_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> ocnt_ff == 4'd0)
      else $error("digest loaded over undelivered words");

   a_round_no_byte: assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> !cmd.put_byte && fill_ff == 6'd0)
      else $error("byte intake during compression");

endmodule

FILE: src/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: controller plus datapath.
// Depends on sha_pkg, sha_req_if, sha_rsp_if, sha_ctrl and sha_dp.
//
//   channel  dir  word contents
//   req      in   msg_byte[7:0], byte_present, end_of_message
//   rsp      out  digest_word[31:0], word_number[2:0], last_word
//
// The hasher takes one message byte per cycle while req is ready; each full 64-byte
// block holds off req for 64 rounds of the single round unit plus the chain add.
// An end word adds one pad or length byte per cycle, one or two compressions and
// a load of the digest buffer.
// The eight digest words drain from a buffer while the next message is taken;
// a second digest waits for that buffer to empty.
// Reset is synchronous; it restores the initial hash values and empties the buffer.
module sha256_byte_stream_hasher import sha_pkg::*; (
   input logic       clock,
   input logic       reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type status;

   sha_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req.valid),
      .byte_present   (req.byte_present),
      .end_of_message (req.end_of_message),
      .in_ready       (req.ready),
      .status         (status),
      .cmd            (cmd)
   );

   sha_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .msg_byte    (req.msg_byte),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .digest_word (rsp.digest_word),
      .word_number (rsp.word_number),
      .last_word   (rsp.last_word)
   );

endmodule
